// ===== hdl/smh_pkg.sv =====
// Shared constants, codes and transaction types for the SPI slave message handshake.
package smh_pkg;

    localparam int          CMD_BYTES      = 6;
    localparam logic [7:0]  CMD_LEN        = 8'(CMD_BYTES);
    localparam logic [7:0]  SHORT_LEN      = 8'd1;
    localparam logic [7:0]  MAX_MESSAGE    = 8'd255;
    localparam logic [7:0]  OVERREAD_RESET = 8'hEE;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'hFF;

    // Event kinds
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ARMED   = 2'd1;
    localparam logic [1:0] OP_DONE    = 2'd2;
    localparam logic [1:0] OP_TIMEOUT = 2'd3;

    // Timer orders
    localparam logic [1:0] TMR_NONE   = 2'd0;
    localparam logic [1:0] TMR_START  = 2'd1;
    localparam logic [1:0] TMR_CANCEL = 2'd2;

    // Buffer selects
    localparam logic SRC_CMD = 1'b0;
    localparam logic SRC_MSG = 1'b1;

    // Configuration register indexes
    localparam logic REG_OVERREAD = 1'b0;
    localparam logic REG_MAX_LEN  = 1'b1;

    // Handshake modes
    localparam logic [3:0] M_IDLE          = 4'd0;
    localparam logic [3:0] M_SEND_ARM_CMD  = 4'd1;
    localparam logic [3:0] M_SEND_CMD      = 4'd2;
    localparam logic [3:0] M_SEND_ARM_MSG  = 4'd3;
    localparam logic [3:0] M_SEND_MSG      = 4'd4;
    localparam logic [3:0] M_SEND_ARM_DONE = 4'd5;
    localparam logic [3:0] M_RECV_ARMING   = 4'd6;
    localparam logic [3:0] M_RECV_READY    = 4'd7;
    localparam logic [3:0] M_IDLE_ARM      = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic        chip_select_high;
        logic [31:0] send_length;
        logic [15:0] send_port;
        logic [7:0]  tx_count;
        logic [7:0]  rx_count;
        logic [31:0] received_length;
        logic [15:0] received_port;
    } t_in_item;

    typedef struct packed {
        logic        send_accepted;
        logic        irq_level;
        logic        arm_buffers;
        logic        tx_source;
        logic [7:0]  tx_length;
        logic        rx_target;
        logic [7:0]  rx_length;
        logic [47:0] command_bytes;
        logic        receive_done;
        logic [15:0] receive_port_out;
        logic        send_done;
        logic [1:0]  timer_action;
    } t_out_item;

    typedef struct packed {
        logic [7:0] overread;
        logic [7:0] limit;
    } t_cfg;

endpackage

// ===== hdl/smh_cfg_regs.sv =====
// Configuration registers and the effective message length limit.
module smh_cfg_regs
    import smh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    logic [7:0] r_overread;
    logic [7:0] r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overread <= OVERREAD_RESET;
            r_max_len  <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OVERREAD: r_overread <= i_cfg_wdata;
                REG_MAX_LEN:  r_max_len  <= i_cfg_wdata;
                default:      r_overread <= r_overread;
            endcase
        end
    end

    always_comb begin
        o_cfg.overread = r_overread;
        o_cfg.limit    = (r_max_len > MAX_MESSAGE) ? MAX_MESSAGE : r_max_len;
    end

endmodule

// ===== hdl/smh_in_stage.sv =====
// Input register stage: takes one event per cycle while o_ready.
module smh_in_stage
    import smh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_in_item o_item,
    input  logic     i_take
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hdl/smh_ctrl.sv =====
// Handshake mode machine, state registers and result register.
module smh_ctrl
    import smh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic [3:0]  r_mode,    n_mode;
    logic        r_irq,     n_irq;
    logic [47:0] r_cmd,     n_cmd;
    logic [7:0]  r_pending, n_pending;
    logic [15:0] r_port,    n_port;
    logic        r_out_valid;
    t_out_item   r_out,     n_out;
    logic        w_fire;
    logic [7:0]  w_send_len;

    function automatic t_out_item set_arm(t_out_item r, logic txs, logic [7:0] txl,
                                          logic rxt, logic [7:0] rxl);
        t_out_item o;
        o             = r;
        o.arm_buffers = 1'b1;
        o.tx_source   = txs;
        o.tx_length   = txl;
        o.rx_target   = rxt;
        o.rx_length   = rxl;
        return o;
    endfunction

    assign o_take      = !r_out_valid || i_out_ready;
    assign w_fire      = i_valid && o_take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Clamp the send length to the active limit
    assign w_send_len = (i_item.send_length > {24'd0, i_cfg.limit}) ? i_cfg.limit
                                                                     : i_item.send_length[7:0];

    always_comb begin
        n_mode    = r_mode;
        n_irq     = r_irq;
        n_cmd     = r_cmd;
        n_pending = r_pending;
        n_port    = r_port;
        n_out     = '0;

        unique case (i_item.op)
            OP_SEND: begin
                if (r_mode == M_IDLE && i_item.chip_select_high) begin
                    n_mode             = M_SEND_ARM_CMD;
                    n_irq              = 1'b0;
                    n_pending          = w_send_len;
                    n_cmd              = {i_item.send_port, 24'd0, w_send_len};
                    n_out.send_accepted = 1'b1;
                    n_out              = set_arm(n_out, SRC_CMD, CMD_LEN, SRC_CMD, CMD_LEN);
                    n_out.timer_action = TMR_START;
                end
            end
            OP_ARMED: begin
                unique case (r_mode)
                    M_SEND_ARM_CMD: begin
                        n_mode = M_SEND_CMD;
                        n_irq  = 1'b1;
                    end
                    M_SEND_ARM_MSG: begin
                        n_mode = M_SEND_MSG;
                        n_irq  = 1'b0;
                    end
                    M_SEND_ARM_DONE: begin
                        n_mode             = M_IDLE;
                        n_irq              = 1'b1;
                        n_out.timer_action = TMR_CANCEL;
                        n_out.send_done    = 1'b1;
                    end
                    M_RECV_ARMING: begin
                        n_mode = M_RECV_READY;
                        n_irq  = 1'b0;
                    end
                    M_IDLE_ARM: begin
                        n_mode = M_IDLE;
                        n_irq  = 1'b1;
                    end
                    default: begin
                        n_irq = 1'b1;
                    end
                endcase
            end
            OP_DONE: begin
                priority if (r_mode == M_SEND_CMD && i_item.tx_count != 8'd0) begin
                    n_mode = M_SEND_ARM_MSG;
                    n_out  = set_arm(n_out, SRC_MSG, r_pending, SRC_CMD, CMD_LEN);
                end else if (r_mode == M_SEND_MSG && i_item.rx_count != 8'd0) begin
                    n_mode = M_SEND_ARM_DONE;
                    n_out  = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end else if (r_mode == M_IDLE && i_item.rx_count != 8'd0) begin
                    if (i_item.received_length <= {24'd0, i_cfg.limit}) begin
                        n_mode             = M_RECV_ARMING;
                        n_port             = i_item.received_port;
                        n_out              = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_MSG,
                                                     i_item.received_length[7:0]);
                        n_out.timer_action = TMR_START;
                    end else begin
                        // drop an oversized command, stay idle
                        n_out = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                    end
                end else if (r_mode == M_RECV_READY && i_item.rx_count != 8'd0) begin
                    n_mode                 = M_IDLE_ARM;
                    n_out.receive_done     = 1'b1;
                    n_out.receive_port_out = r_port;
                    n_out.timer_action     = TMR_CANCEL;
                    n_out = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end else begin
                    // unexpected transfer: fall back to idle
                    n_mode = M_IDLE;
                    n_cmd  = {r_cmd[47:8], i_cfg.overread};
                    n_out  = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end
            end
            OP_TIMEOUT: begin
                n_mode = M_IDLE_ARM;
                n_cmd  = {r_cmd[47:8], i_cfg.overread};
                n_out  = set_arm(n_out, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        n_out.irq_level     = n_irq;
        n_out.command_bytes = n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_irq       <= 1'b1;
            r_cmd       <= {40'd0, OVERREAD_RESET};
            r_pending   <= 8'd0;
            r_port      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_out_valid <= i_valid;
            end
            if (w_fire) begin
                r_mode    <= n_mode;
                r_irq     <= n_irq;
                r_cmd     <= n_cmd;
                r_pending <= n_pending;
                r_port    <= n_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/spi_slave_message_handshake.sv =====
// Top level of the SPI slave message handshake controller.
// Takes one event transaction per cycle on the input channel while o_in_ready is high and
// returns exactly one result transaction for each. An event waits in the input register
// until the mode machine takes it; its result is then presented from the result register
// that follows the mode machine. Both channels stall independently: while a finished
// result waits, one further event is taken into the input register and held there. The
// only loop is the mode and buffer state, updated once per event. Configuration writes
// take effect at the next edge and are meant for idle periods; index 0 is the overread
// character, index 1 the maximum message length.
module spi_slave_message_handshake
    import smh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_chip_select_high,
    input  logic [31:0] i_send_length,
    input  logic [15:0] i_send_port,
    input  logic [7:0]  i_tx_count,
    input  logic [7:0]  i_rx_count,
    input  logic [31:0] i_received_length,
    input  logic [15:0] i_received_port,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_send_accepted,
    output logic        o_irq_level,
    output logic        o_arm_buffers,
    output logic        o_tx_source,
    output logic [7:0]  o_tx_length,
    output logic        o_rx_target,
    output logic [7:0]  o_rx_length,
    output logic [47:0] o_command_bytes,
    output logic        o_receive_done,
    output logic [15:0] o_receive_port_out,
    output logic        o_send_done,
    output logic [1:0]  o_timer_action
);

    t_cfg      w_cfg;
    t_in_item  w_in_item;
    t_in_item  w_stage_item;
    logic      w_stage_valid;
    logic      w_take;
    t_out_item w_out;

    always_comb begin
        w_in_item.op               = i_op;
        w_in_item.chip_select_high = i_chip_select_high;
        w_in_item.send_length      = i_send_length;
        w_in_item.send_port        = i_send_port;
        w_in_item.tx_count         = i_tx_count;
        w_in_item.rx_count         = i_rx_count;
        w_in_item.received_length  = i_received_length;
        w_in_item.received_port    = i_received_port;
    end

    smh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    smh_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item),
        .i_take  (w_take)
    );

    smh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (w_out)
    );

    assign o_send_accepted    = w_out.send_accepted;
    assign o_irq_level        = w_out.irq_level;
    assign o_arm_buffers      = w_out.arm_buffers;
    assign o_tx_source        = w_out.tx_source;
    assign o_tx_length        = w_out.tx_length;
    assign o_rx_target        = w_out.rx_target;
    assign o_rx_length        = w_out.rx_length;
    assign o_command_bytes    = w_out.command_bytes;
    assign o_receive_done     = w_out.receive_done;
    assign o_receive_port_out = w_out.receive_port_out;
    assign o_send_done        = w_out.send_done;
    assign o_timer_action     = w_out.timer_action;

`ifndef SYNTH
    // accepted send arms the command buffer both ways and starts the timer
    a_send_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_accepted |->
            o_arm_buffers && o_tx_length == CMD_LEN && o_rx_length == CMD_LEN
            && o_timer_action == TMR_START && !o_irq_level)
        else $error("send accept without command arm");

    // delivered message cancels the timer and re-arms the command buffer
    a_recv_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_receive_done |->
            o_timer_action == TMR_CANCEL && o_arm_buffers && o_rx_target == SRC_CMD)
        else $error("receive done without timer cancel");

    // send completion releases the IRQ line and never re-arms
    a_send_done_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_done |-> o_irq_level && !o_arm_buffers)
        else $error("send done with IRQ asserted");

    // an event is never lost between input stage and result register
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage_valid && w_take |=> o_out_valid)
        else $error("processed event produced no result");
`endif

endmodule

// ===== tb/sv/smh_result_checker.sv =====
// Result checker for the SPI slave message handshake: predicts every result and compares it.
`timescale 1ns / 1ps
module smh_result_checker
    import smh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_chip_select_high,
    input  logic [31:0] i_send_length,
    input  logic [15:0] i_send_port,
    input  logic [7:0]  i_tx_count,
    input  logic [7:0]  i_rx_count,
    input  logic [31:0] i_received_length,
    input  logic [15:0] i_received_port,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_send_accepted,
    input  logic        i_irq_level,
    input  logic        i_arm_buffers,
    input  logic        i_tx_source,
    input  logic [7:0]  i_tx_length,
    input  logic        i_rx_target,
    input  logic [7:0]  i_rx_length,
    input  logic [47:0] i_command_bytes,
    input  logic        i_receive_done,
    input  logic [15:0] i_receive_port_out,
    input  logic        i_send_done,
    input  logic [1:0]  i_timer_action,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int PRINT_CAP = 40;

    // Shadow of the handshake state and of the configuration
    logic [7:0]  overread_char;
    logic [7:0]  len_limit;
    logic [3:0]  mode;
    logic        irq_line;
    logic [47:0] cmd_buf;
    logic [7:0]  pend_len;
    logic [15:0] rx_port;

    t_out_item   expected_results[$];
    t_out_item   want;
    int          mismatch_count    = 0;
    int          outstanding_count = 0;
    int          results_checked   = 0;

    t_in_item    seen_event;
    t_out_item   seen_result;

    assign seen_event  = {i_op, i_chip_select_high, i_send_length, i_send_port,
                          i_tx_count, i_rx_count, i_received_length, i_received_port};
    assign seen_result = {i_send_accepted, i_irq_level, i_arm_buffers, i_tx_source,
                          i_tx_length, i_rx_target, i_rx_length, i_command_bytes,
                          i_receive_done, i_receive_port_out, i_send_done, i_timer_action};

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input logic [47:0] got,
                                 input logic [47:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d, %s: got %0h, want %0h",
                                      results_checked, what, got, exp_val));
    endtask

    function automatic void arm_order(inout t_out_item r, input logic tx_src,
                                      input logic [7:0] tx_len, input logic rx_tgt,
                                      input logic [7:0] rx_len);
        r.arm_buffers = 1'b1;
        r.tx_source   = tx_src;
        r.tx_length   = tx_len;
        r.rx_target   = rx_tgt;
        r.rx_length   = rx_len;
    endfunction

    // Apply one event to the shadow state and return the result it must produce
    function automatic t_out_item advance_handshake(input t_in_item ev);
        t_out_item  r;
        logic [7:0] lim;
        logic [7:0] len;
        r   = '0;
        lim = (len_limit > MAX_MESSAGE) ? MAX_MESSAGE : len_limit;
        case (ev.op)
            OP_SEND: begin
                if (mode == M_IDLE && ev.chip_select_high) begin
                    len      = (ev.send_length > 32'(lim)) ? lim : ev.send_length[7:0];
                    mode     = M_SEND_ARM_CMD;
                    irq_line = 1'b0;
                    pend_len = len;
                    cmd_buf  = {ev.send_port, 24'd0, len};
                    r.send_accepted = 1'b1;
                    r.timer_action  = TMR_START;
                    arm_order(r, SRC_CMD, CMD_LEN, SRC_CMD, CMD_LEN);
                end
            end
            OP_ARMED: begin
                case (mode)
                    M_SEND_ARM_CMD: begin
                        mode     = M_SEND_CMD;
                        irq_line = 1'b1;
                    end
                    M_SEND_ARM_MSG: begin
                        mode     = M_SEND_MSG;
                        irq_line = 1'b0;
                    end
                    M_SEND_ARM_DONE: begin
                        mode           = M_IDLE;
                        irq_line       = 1'b1;
                        r.send_done    = 1'b1;
                        r.timer_action = TMR_CANCEL;
                    end
                    M_RECV_ARMING: begin
                        mode     = M_RECV_READY;
                        irq_line = 1'b0;
                    end
                    M_IDLE_ARM: begin
                        mode     = M_IDLE;
                        irq_line = 1'b1;
                    end
                    default: irq_line = 1'b1;
                endcase
            end
            OP_DONE: begin
                if (mode == M_SEND_CMD && ev.tx_count != 8'd0) begin
                    mode = M_SEND_ARM_MSG;
                    arm_order(r, SRC_MSG, pend_len, SRC_CMD, CMD_LEN);
                end else if (mode == M_SEND_MSG && ev.rx_count != 8'd0) begin
                    mode = M_SEND_ARM_DONE;
                    arm_order(r, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end else if (mode == M_IDLE && ev.rx_count != 8'd0) begin
                    if (ev.received_length <= 32'(lim)) begin
                        mode           = M_RECV_ARMING;
                        rx_port        = ev.received_port;
                        r.timer_action = TMR_START;
                        arm_order(r, SRC_CMD, SHORT_LEN, SRC_MSG, ev.received_length[7:0]);
                    end else begin
                        // drop an oversized command, stay idle
                        arm_order(r, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                    end
                end else if (mode == M_RECV_READY && ev.rx_count != 8'd0) begin
                    mode               = M_IDLE_ARM;
                    r.receive_done     = 1'b1;
                    r.receive_port_out = rx_port;
                    r.timer_action     = TMR_CANCEL;
                    arm_order(r, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end else begin
                    // out-of-sequence transfer: fall back to idle, timer untouched
                    mode         = M_IDLE;
                    cmd_buf[7:0] = overread_char;
                    arm_order(r, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
                end
            end
            OP_TIMEOUT: begin
                mode         = M_IDLE_ARM;
                cmd_buf[7:0] = overread_char;
                arm_order(r, SRC_CMD, SHORT_LEN, SRC_CMD, CMD_LEN);
            end
        endcase
        r.irq_level     = irq_line;
        r.command_bytes = cmd_buf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            overread_char = OVERREAD_RESET;
            len_limit     = MAX_LEN_RESET;
            mode          = M_IDLE;
            irq_line      = 1'b1;
            cmd_buf       = {40'd0, OVERREAD_RESET};
            pend_len      = '0;
            rx_port       = '0;
            expected_results.delete();
            outstanding_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no event waiting: %h",
                                              results_checked, seen_result));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("send_accepted", 48'(i_send_accepted), 48'(want.send_accepted));
                    compare_field("irq_level", 48'(i_irq_level), 48'(want.irq_level));
                    compare_field("arm_buffers", 48'(i_arm_buffers), 48'(want.arm_buffers));
                    compare_field("tx_source", 48'(i_tx_source), 48'(want.tx_source));
                    compare_field("tx_length", 48'(i_tx_length), 48'(want.tx_length));
                    compare_field("rx_target", 48'(i_rx_target), 48'(want.rx_target));
                    compare_field("rx_length", 48'(i_rx_length), 48'(want.rx_length));
                    compare_field("command_bytes", i_command_bytes, want.command_bytes);
                    compare_field("receive_done", 48'(i_receive_done), 48'(want.receive_done));
                    compare_field("receive_port_out", 48'(i_receive_port_out),
                                  48'(want.receive_port_out));
                    compare_field("send_done", 48'(i_send_done), 48'(want.send_done));
                    compare_field("timer_action", 48'(i_timer_action), 48'(want.timer_action));
                end
                results_checked++;
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(advance_handshake(seen_event));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OVERREAD: overread_char = i_cfg_wdata;
                    REG_MAX_LEN:  len_limit     = i_cfg_wdata;
                endcase
            end
            outstanding_count = expected_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the SPI slave message handshake: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import smh_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int PHASE_EVENTS = 330;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 2000;

    typedef enum int {SEQ_SEND, SEQ_RECEIVE, SEQ_NOISE} t_seq_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic        i_chip_select_high;
    logic [31:0] i_send_length;
    logic [15:0] i_send_port;
    logic [7:0]  i_tx_count;
    logic [7:0]  i_rx_count;
    logic [31:0] i_received_length;
    logic [15:0] i_received_port;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_send_accepted;
    logic        o_irq_level;
    logic        o_arm_buffers;
    logic        o_tx_source;
    logic [7:0]  o_tx_length;
    logic        o_rx_target;
    logic [7:0]  o_rx_length;
    logic [47:0] o_command_bytes;
    logic        o_receive_done;
    logic [15:0] o_receive_port_out;
    logic        o_send_done;
    logic [1:0]  o_timer_action;

    int          mismatches;
    int          results_outstanding;
    int          events_driven  = 0;
    int          stalled_cycles = 0;
    logic [7:0]  cur_limit      = MAX_LEN_RESET;
    logic        tx_steady      = 1'b0;
    logic        rx_steady      = 1'b0;
    logic        hold_off_req   = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    spi_slave_message_handshake dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .o_in_ready,
        .i_op, .i_chip_select_high, .i_send_length, .i_send_port,
        .i_tx_count, .i_rx_count, .i_received_length, .i_received_port,
        .o_out_valid, .i_out_ready,
        .o_send_accepted, .o_irq_level, .o_arm_buffers, .o_tx_source, .o_tx_length,
        .o_rx_target, .o_rx_length, .o_command_bytes, .o_receive_done,
        .o_receive_port_out, .o_send_done, .o_timer_action
    );

    smh_result_checker result_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_op, .i_chip_select_high, .i_send_length, .i_send_port,
        .i_tx_count, .i_rx_count, .i_received_length, .i_received_port,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_send_accepted(o_send_accepted), .i_irq_level(o_irq_level),
        .i_arm_buffers(o_arm_buffers), .i_tx_source(o_tx_source),
        .i_tx_length(o_tx_length), .i_rx_target(o_rx_target), .i_rx_length(o_rx_length),
        .i_command_bytes(o_command_bytes), .i_receive_done(o_receive_done),
        .i_receive_port_out(o_receive_port_out), .i_send_done(o_send_done),
        .i_timer_action(o_timer_action),
        .o_mismatches(mismatches), .o_outstanding(results_outstanding)
    );

    // Result side: random stalls, a steady stretch, and one long hold-off on request
    initial begin
        int hold_count;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_out_ready <= rx_steady || ($urandom_range(99) >= 26);
            end
        end
    end

    // Abort when no transaction, and no register write, moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stalled_cycles <= 0;
        else if (stalled_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else
            stalled_cycles <= stalled_cycles + 1;
    end

    function automatic t_in_item random_event();
        t_in_item ev;
        ev.op                = 2'($urandom);
        ev.chip_select_high  = 1'($urandom);
        ev.send_length       = $urandom;
        ev.send_port         = 16'($urandom);
        ev.tx_count          = 8'($urandom);
        ev.rx_count          = 8'($urandom);
        ev.received_length   = $urandom;
        ev.received_port     = 16'($urandom);
        return ev;
    endfunction

    // Mostly within the limit, some just past it, a few anywhere in 32 bits
    function automatic logic [31:0] pick_length(input logic [7:0] lim);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 32'($urandom_range(int'(lim)));
        else if (sel < 85)
            return 32'(lim) + 32'($urandom_range(8, 1));
        else
            return $urandom;
    endfunction

    // Entered and left at a falling edge; holds valid until the transaction goes through
    task automatic drive_event(input t_in_item ev);
        while (!tx_steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_op, i_chip_select_high, i_send_length, i_send_port,
         i_tx_count, i_rx_count, i_received_length, i_received_port} <= ev;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
        events_driven++;
    endtask

    task automatic drive_op(input logic [1:0] op, input logic cs, input logic [7:0] txc,
                            input logic [7:0] rxc, input logic [31:0] len,
                            input logic [15:0] port);
        t_in_item ev;
        ev                  = random_event();
        ev.op               = op;
        ev.chip_select_high = cs;
        ev.tx_count         = txc;
        ev.rx_count         = rxc;
        ev.send_length      = len;
        ev.received_length  = len;
        ev.send_port        = port;
        ev.received_port    = port;
        drive_event(ev);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_MAX_LEN)
            cur_limit = value;
    endtask

    // Drop valid and wait for every result, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_outstanding != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random_traffic(input int quota);
        t_in_item  ev;
        t_seq_kind kind;
        int        steps;
        int        stop_at;
        int        pick;
        stop_at = events_driven + quota;
        while (events_driven < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                kind  = SEQ_SEND;
                steps = 6;
            end else if (pick < 85) begin
                kind  = SEQ_RECEIVE;
                steps = 4;
            end else begin
                kind  = SEQ_NOISE;
                steps = $urandom_range(6, 1);
            end
            for (int step = 0; step < steps; step++) begin
                ev = random_event();
                if (kind == SEQ_SEND) begin
                    case (step)
                        0: begin
                            ev.op               = OP_SEND;
                            ev.chip_select_high = ($urandom_range(99) < 92);
                            ev.send_length      = pick_length(cur_limit);
                        end
                        2: begin
                            ev.op       = OP_DONE;
                            ev.tx_count = 8'($urandom_range(255, 1));
                        end
                        4: begin
                            ev.op       = OP_DONE;
                            ev.rx_count = 8'($urandom_range(255, 1));
                        end
                        default: ev.op = OP_ARMED;
                    endcase
                end else if (kind == SEQ_RECEIVE) begin
                    case (step)
                        0: begin
                            ev.op              = OP_DONE;
                            ev.rx_count        = 8'($urandom_range(255, 1));
                            ev.received_length = pick_length(cur_limit);
                        end
                        2: begin
                            ev.op       = OP_DONE;
                            ev.rx_count = 8'($urandom_range(255, 1));
                        end
                        default: ev.op = OP_ARMED;
                    endcase
                end
                // break a well-formed sequence now and then
                if (kind != SEQ_NOISE && $urandom_range(99) < 5)
                    ev = random_event();
                drive_event(ev);
            end
            if (kind == SEQ_NOISE && $urandom_range(99) < 70) begin
                // recover to idle through a timeout and its re-arm
                ev    = random_event();
                ev.op = OP_TIMEOUT;
                drive_event(ev);
                ev    = random_event();
                ev.op = OP_ARMED;
                drive_event(ev);
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_OVERREAD;
        i_cfg_wdata        = '0;
        i_in_valid         = 1'b0;
        i_op               = OP_SEND;
        i_chip_select_high = 1'b0;
        i_send_length      = '0;
        i_send_port        = '0;
        i_tx_count         = '0;
        i_rx_count         = '0;
        i_received_length  = '0;
        i_received_port    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_OVERREAD, OVERREAD_RESET);
        write_reg(REG_MAX_LEN, MAX_LEN_RESET);

        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);            // armed while idle
        drive_op(OP_SEND, 1'b0, 8'd0, 8'd0, 32'd4, 16'd2);             // chip selected: refuse
        drive_op(OP_SEND, 1'b1, 8'd0, 8'd0, 32'hFFFF_FFFF, 16'hFFFF);  // clamp the length
        drive_op(OP_SEND, 1'b1, 8'd0, 8'd0, 32'd5, 16'd1);             // busy: refuse
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b1, 8'hFF, 8'h00, 32'd0, 16'd0);           // command read
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b0, 8'h00, 8'hFF, 32'd0, 16'd0);           // message read
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);            // send complete
        drive_op(OP_DONE, 1'b0, 8'd0, 8'd1, 32'd255, 16'hFFFF);        // receive at the limit
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b0, 8'hFF, 8'd0, 32'd0, 16'd0);            // nothing received
        drive_op(OP_DONE, 1'b0, 8'd0, 8'd3, 32'd0, 16'h1234);          // zero-length receive
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b0, 8'd0, 8'd1, 32'd0, 16'd0);             // deliver
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b0, 8'd0, 8'd1, 32'd256, 16'h00FF);        // command too long
        drive_op(OP_DONE, 1'b0, 8'd1, 8'd0, 32'd0, 16'd0);             // stray done in idle
        drive_op(OP_SEND, 1'b1, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_TIMEOUT, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);          // timeout mid-send
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_SEND, 1'b1, 8'd0, 8'd0, 32'd7, 16'h8001);
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_DONE, 1'b0, 8'd0, 8'd9, 32'd0, 16'd0);             // command not read
        drive_op(OP_TIMEOUT, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drive_op(OP_ARMED, 1'b0, 8'd0, 8'd0, 32'd0, 16'd0);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_OVERREAD, 8'h00);
                    write_reg(REG_MAX_LEN, MAX_MESSAGE);
                end
                1: begin
                    write_reg(REG_OVERREAD, 8'hFF);
                    write_reg(REG_MAX_LEN, 8'd0);
                    hold_off_req = 1'b1;
                end
                2: begin
                    write_reg(REG_OVERREAD, 8'($urandom));
                    write_reg(REG_MAX_LEN, 8'($urandom_range(254, 1)));
                    tx_steady = 1'b1;
                    rx_steady = 1'b1;
                end
                3: begin
                    write_reg(REG_OVERREAD, 8'($urandom));
                    write_reg(REG_MAX_LEN, CMD_LEN);
                    tx_steady = 1'b0;
                    rx_steady = 1'b0;
                end
                default: begin
                    write_reg(REG_OVERREAD, 8'h5A);
                    write_reg(REG_MAX_LEN, 8'($urandom));
                end
            endcase
            run_random_traffic(PHASE_EVENTS);
            drain_results();
        end

        if (mismatches == 0 && results_outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== spi_slave_message_handshake.f =====
hdl/smh_pkg.sv
hdl/smh_cfg_regs.sv
hdl/smh_in_stage.sv
hdl/smh_ctrl.sv
hdl/spi_slave_message_handshake.sv
tb/sv/smh_result_checker.sv
tb/sv/tb_top.sv
